// ===== src/jtlc_pkg.sv =====
// Shared types and constants for the journal transaction log controller.
// No dependencies; imported by every module of the block except the generic RAM.
`default_nettype none

package jtlc_pkg;

    localparam int LOG_ENTRIES = 30;
    localparam int IDX_W       = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;
    localparam int CNT_W       = 5;
    localparam int BLK_W       = 32;
    localparam int KIND_W      = 4;
    localparam int CMD_W       = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int BUDGET_W    = 5;
    localparam int OPS_W       = 5;

    // input commands
    localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd0;
    localparam logic [CMD_W-1:0] CMD_END   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOG_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOG_CAP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BUDGET    = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_GRANTED    = 4'd0;
    localparam logic [KIND_W-1:0] KIND_REFUSED    = 4'd1;
    localparam logic [KIND_W-1:0] KIND_ENDED_OPEN = 4'd2;
    localparam logic [KIND_W-1:0] KIND_APPENDED   = 4'd3;
    localparam logic [KIND_W-1:0] KIND_ABSORBED   = 4'd4;
    localparam logic [KIND_W-1:0] KIND_FULL_ERR   = 4'd5;
    localparam logic [KIND_W-1:0] KIND_END_ERR    = 4'd6;
    localparam logic [KIND_W-1:0] KIND_COPY_LOG   = 4'd7;
    localparam logic [KIND_W-1:0] KIND_HDR_WRITE  = 4'd8;
    localparam logic [KIND_W-1:0] KIND_INSTALL    = 4'd9;
    localparam logic [KIND_W-1:0] KIND_HDR_CLEAR  = 4'd10;
    localparam logic [KIND_W-1:0] KIND_EMPTY      = 4'd11;

    // controller to datapath commands
    typedef struct packed {
        logic              load;
        logic              idx_clr;
        logic              idx_inc;
        logic              rd_en;
        logic              ram_we;
        logic              ent_inc;
        logic              ent_clr;
        logic              ops_inc;
        logic              ops_dec;
        logic              emit;
        logic [KIND_W-1:0] kind;
        logic              last;
    } jtlc_ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             admit_ok;
        logic             ops_zero;
        logic             ops_one;
        logic             ent_zero;
        logic             full;
        logic             idx_last;
        logic             match;
        logic             out_free;
    } jtlc_stat_t;

endpackage

`default_nettype wire

// ===== src/jtlc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module jtlc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 30
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic                                        re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/jtlc_datapath.sv =====
// Datapath: configuration registers, counters, block table RAM and result register.
// Depends on jtlc_pkg and jtlc_ram.
`default_nettype none

module jtlc_datapath
    import jtlc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BLK_W-1:0]     cfg_data,
    input  wire logic [CMD_W-1:0]     cmd,
    input  wire logic [BLK_W-1:0]     block_no,
    input  wire jtlc_ctl_t            ctl,
    output jtlc_stat_t                stat,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [KIND_W-1:0]         kind,
    output logic [BLK_W-1:0]          src_block,
    output logic [BLK_W-1:0]          dst_block,
    output logic [CNT_W-1:0]          header_count,
    output logic                      last
);

    localparam int PROD_W = OPS_W + 1 + BUDGET_W;
    localparam int NEED_W = PROD_W + 1;

    logic [BLK_W-1:0]    log_start_reg;
    logic [CNT_W-1:0]    log_cap_reg;
    logic [BUDGET_W-1:0] budget_reg;

    logic [CMD_W-1:0]    cmd_reg;
    logic [BLK_W-1:0]    blk_reg;
    logic [CNT_W-1:0]    entry_count_reg;
    logic [CNT_W-1:0]    entry_count_next;
    logic [OPS_W-1:0]    active_ops_reg;
    logic [OPS_W-1:0]    active_ops_next;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    idx_next;

    logic                out_valid_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [BLK_W-1:0]    src_reg;
    logic [BLK_W-1:0]    dst_reg;
    logic [CNT_W-1:0]    hc_reg;
    logic                last_reg;

    logic [BLK_W-1:0]    rdata;
    logic [BLK_W-1:0]    slot_block;
    logic [BLK_W-1:0]    src_sel;
    logic [BLK_W-1:0]    dst_sel;
    logic [CNT_W-1:0]    hc_sel;
    logic [OPS_W:0]      ops_plus;
    logic [PROD_W-1:0]   reserve;
    logic [NEED_W-1:0]   need;
    logic                out_free;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_start_reg <= BLK_W'(2);
            log_cap_reg   <= CNT_W'(30);
            budget_reg    <= BUDGET_W'(10);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LOG_START: log_start_reg <= cfg_data;
                REG_LOG_CAP:   log_cap_reg   <= cfg_data[CNT_W-1:0];
                REG_BUDGET:    budget_reg    <= cfg_data[BUDGET_W-1:0];
                default:       ;
            endcase
        end
    end

    // captured transaction
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd;
            blk_reg <= block_no;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (ctl.idx_clr)
        begin
            idx_next = '0;
        end
        else if (ctl.idx_inc)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end

        entry_count_next = entry_count_reg;
        if (ctl.ent_clr)
        begin
            entry_count_next = '0;
        end
        else if (ctl.ent_inc)
        begin
            entry_count_next = entry_count_reg + CNT_W'(1);
        end

        active_ops_next = active_ops_reg;
        if (ctl.ops_inc)
        begin
            active_ops_next = active_ops_reg + OPS_W'(1);
        end
        else if (ctl.ops_dec)
        begin
            active_ops_next = active_ops_reg - OPS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            active_ops_reg  <= '0;
            idx_reg         <= '0;
        end
        else
        begin
            entry_count_reg <= entry_count_next;
            active_ops_reg  <= active_ops_next;
            idx_reg         <= idx_next;
        end
    end

    // read address follows idx_next so the registered read data lines up with idx_reg
    jtlc_ram #(
        .WIDTH (BLK_W),
        .DEPTH (LOG_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ctl.ram_we),
        .waddr (entry_count_reg[IDX_W-1:0]),
        .wdata (blk_reg),
        .re    (ctl.rd_en),
        .raddr (idx_next),
        .rdata (rdata)
    );

    // admission: entry_count + (active_ops + 1) * budget <= LOG_ENTRIES and active_ops below its maximum
    assign ops_plus = {1'b0, active_ops_reg} + (OPS_W + 1)'(1);
    assign reserve  = PROD_W'(ops_plus) * PROD_W'(budget_reg);
    assign need     = NEED_W'(reserve) + NEED_W'(entry_count_reg);

    assign slot_block = log_start_reg + BLK_W'(idx_reg) + BLK_W'(1);
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        stat.cmd      = cmd_reg;
        stat.admit_ok = (need <= NEED_W'(LOG_ENTRIES)) && (active_ops_reg != '1);
        stat.ops_zero = (active_ops_reg == '0);
        stat.ops_one  = (active_ops_reg == OPS_W'(1));
        stat.ent_zero = (entry_count_reg == '0);
        stat.full     = (entry_count_reg >= CNT_W'(LOG_ENTRIES)) ||
                        (entry_count_reg >= log_cap_reg);
        stat.idx_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == entry_count_reg);
        stat.match    = (rdata == blk_reg);
        stat.out_free = out_free;
    end

    always_comb
    begin
        src_sel = '0;
        dst_sel = '0;
        hc_sel  = '0;
        unique case (ctl.kind)
            KIND_COPY_LOG:
            begin
                src_sel = rdata;
                dst_sel = slot_block;
            end
            KIND_HDR_WRITE:
            begin
                dst_sel = log_start_reg;
                hc_sel  = entry_count_reg;
            end
            KIND_INSTALL:
            begin
                src_sel = slot_block;
                dst_sel = rdata;
            end
            KIND_HDR_CLEAR:
            begin
                dst_sel = log_start_reg;
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            kind_reg <= ctl.kind;
            src_reg  <= src_sel;
            dst_reg  <= dst_sel;
            hc_reg   <= hc_sel;
            last_reg <= ctl.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign src_block    = src_reg;
    assign dst_block    = dst_reg;
    assign header_count = hc_reg;
    assign last         = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= CNT_W'(LOG_ENTRIES))
        else $error("entry count beyond table depth");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> out_free)
        else $error("result overwritten before it was taken");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ram_we |-> !stat.full)
        else $error("table written while full");

    a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rd_en |-> (CNT_W'(idx_next) < entry_count_reg))
        else $error("table read beyond logged entries");

endmodule

`default_nettype wire

// ===== src/jtlc_ctrl.sv =====
// Controller state machine: dispatch, table search and commit sequencing.
// Depends on jtlc_pkg.
`default_nettype none

module jtlc_ctrl
    import jtlc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire jtlc_stat_t stat,
    output jtlc_ctl_t       ctl
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DISPATCH = 4'd1;
    localparam logic [3:0] ST_SEARCH   = 4'd2;
    localparam logic [3:0] ST_ABSORB   = 4'd3;
    localparam logic [3:0] ST_APPEND   = 4'd4;
    localparam logic [3:0] ST_COPY     = 4'd5;
    localparam logic [3:0] ST_HEADER   = 4'd6;
    localparam logic [3:0] ST_INSTALL  = 4'd7;
    localparam logic [3:0] ST_CLEAR    = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        ctl        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end

            ST_DISPATCH:
            begin
                unique case (stat.cmd)
                    CMD_BEGIN:
                    begin
                        if (stat.out_free)
                        begin
                            ctl.emit    = 1'b1;
                            ctl.last    = 1'b1;
                            ctl.kind    = stat.admit_ok ? KIND_GRANTED : KIND_REFUSED;
                            ctl.ops_inc = stat.admit_ok;
                            state_next  = ST_IDLE;
                        end
                    end
                    CMD_END:
                    begin
                        if (!stat.ops_zero && stat.ops_one && !stat.ent_zero)
                        begin
                            // last end with blocks logged: start the commit
                            ctl.ops_dec = 1'b1;
                            ctl.idx_clr = 1'b1;
                            ctl.rd_en   = 1'b1;
                            state_next  = ST_COPY;
                        end
                        else if (stat.out_free)
                        begin
                            ctl.emit = 1'b1;
                            ctl.last = 1'b1;
                            if (stat.ops_zero)
                            begin
                                ctl.kind = KIND_END_ERR;
                            end
                            else
                            begin
                                ctl.ops_dec = 1'b1;
                                ctl.kind    = stat.ops_one ? KIND_EMPTY : KIND_ENDED_OPEN;
                            end
                            state_next = ST_IDLE;
                        end
                    end
                    CMD_WRITE:
                    begin
                        if (stat.full)
                        begin
                            if (stat.out_free)
                            begin
                                ctl.emit   = 1'b1;
                                ctl.last   = 1'b1;
                                ctl.kind   = KIND_FULL_ERR;
                                state_next = ST_IDLE;
                            end
                        end
                        else if (stat.ent_zero)
                        begin
                            state_next = ST_APPEND;
                        end
                        else
                        begin
                            ctl.idx_clr = 1'b1;
                            ctl.rd_en   = 1'b1;
                            state_next  = ST_SEARCH;
                        end
                    end
                    CMD_NONE:
                    begin
                        state_next = ST_IDLE;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_SEARCH:
            begin
                if (stat.match)
                begin
                    state_next = ST_ABSORB;
                end
                else if (stat.idx_last)
                begin
                    state_next = ST_APPEND;
                end
                else
                begin
                    ctl.idx_inc = 1'b1;
                    ctl.rd_en   = 1'b1;
                end
            end

            ST_ABSORB:
            begin
                if (stat.out_free)
                begin
                    ctl.emit   = 1'b1;
                    ctl.last   = 1'b1;
                    ctl.kind   = KIND_ABSORBED;
                    state_next = ST_IDLE;
                end
            end

            ST_APPEND:
            begin
                if (stat.out_free)
                begin
                    ctl.ram_we  = 1'b1;
                    ctl.ent_inc = 1'b1;
                    ctl.emit    = 1'b1;
                    ctl.last    = 1'b1;
                    ctl.kind    = KIND_APPENDED;
                    state_next  = ST_IDLE;
                end
            end

            ST_COPY:
            begin
                if (stat.out_free)
                begin
                    ctl.emit = 1'b1;
                    ctl.kind = KIND_COPY_LOG;
                    if (stat.idx_last)
                    begin
                        state_next = ST_HEADER;
                    end
                    else
                    begin
                        ctl.idx_inc = 1'b1;
                        ctl.rd_en   = 1'b1;
                    end
                end
            end

            ST_HEADER:
            begin
                if (stat.out_free)
                begin
                    ctl.emit    = 1'b1;
                    ctl.kind    = KIND_HDR_WRITE;
                    ctl.idx_clr = 1'b1;
                    ctl.rd_en   = 1'b1;
                    state_next  = ST_INSTALL;
                end
            end

            ST_INSTALL:
            begin
                if (stat.out_free)
                begin
                    ctl.emit = 1'b1;
                    ctl.kind = KIND_INSTALL;
                    if (stat.idx_last)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        ctl.idx_inc = 1'b1;
                        ctl.rd_en   = 1'b1;
                    end
                end
            end

            ST_CLEAR:
            begin
                if (stat.out_free)
                begin
                    ctl.emit    = 1'b1;
                    ctl.last    = 1'b1;
                    ctl.kind    = KIND_HDR_CLEAR;
                    ctl.ent_clr = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_DISPATCH))
        else $error("accepted transaction not dispatched");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.emit && ctl.last) |=> (state_reg == ST_IDLE))
        else $error("final result without return to idle");

endmodule

`default_nettype wire

// ===== src/journal_transaction_log_controller.sv =====
// Top level of the redo-log controller: ties the controller to the datapath.
// Depends on jtlc_pkg, jtlc_ctrl and jtlc_datapath.
//
//  channel | handshake                | payload
//  --------+--------------------------+-----------------------------------------------
//  in      | in_valid / in_ready      | cmd, block_no
//  out     | out_valid / out_ready    | kind, src_block, dst_block, header_count, last
//  cfg     | cfg_we (no wait)         | cfg_index, cfg_data
//
// One transaction at a time: accept, dispatch, then results.
// Begin, end and full error load the result register from the dispatch state once it is free;
// an end that starts a commit goes to the copy state instead. A block write walks the table
// one entry a cycle (RAM read port), then loads its result from the absorb or append state.
// A commit emits 2*entry_count+2 results, one per cycle while out_ready holds.
// Output stalls just hold the sequencer; results stay in the output register.
// Reset is asynchronous; the table RAM is not cleared, only entries below the count are read.
`default_nettype none

module journal_transaction_log_controller
    import jtlc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BLK_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [CMD_W-1:0]     cmd,
    input  wire logic [BLK_W-1:0]     block_no,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [KIND_W-1:0]         kind,
    output logic [BLK_W-1:0]          src_block,
    output logic [BLK_W-1:0]          dst_block,
    output logic [CNT_W-1:0]          header_count,
    output logic                      last
);

    jtlc_ctl_t  ctl;
    jtlc_stat_t stat;

    jtlc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    jtlc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .block_no     (block_no),
        .ctl          (ctl),
        .stat         (stat),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .src_block    (src_block),
        .dst_block    (dst_block),
        .header_count (header_count),
        .last         (last)
    );

endmodule

`default_nettype wire
